FILE: src/i2cbs_pkg.sv
// shared types, codes and constants of the i2c master bit sequencer
`timescale 1ns / 1ps

package i2cbs_pkg;

  localparam int ByteBits = 8;
  localparam int BitCntW  = $clog2(ByteBits);
  localparam int PcW      = 5;

  typedef logic [PcW-1:0]     pc_t;
  typedef logic [BitCntW-1:0] bit_cnt_t;

  // request codes
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_STOP   = 3'd1;
  localparam logic [2:0] REQ_WRITE  = 3'd2;
  localparam logic [2:0] REQ_WRINV  = 3'd3;
  localparam logic [2:0] REQ_ACKCLK = 3'd4;
  localparam logic [2:0] REQ_RDACK  = 3'd5;
  localparam logic [2:0] REQ_RDNACK = 3'd6;
  localparam logic [2:0] REQ_NONE   = 3'd7;

  // microprogram entry points and loop heads
  localparam pc_t PC_START  = pc_t'(0);
  localparam pc_t PC_STOP   = pc_t'(4);
  localparam pc_t PC_WRITE  = pc_t'(7);
  localparam pc_t PC_WR_BIT = pc_t'(8);
  localparam pc_t PC_ACKCLK = pc_t'(11);
  localparam pc_t PC_READ   = pc_t'(13);

  typedef enum logic [1:0] {
    SCL_KEEP,
    SCL_LO,
    SCL_HI
  } scl_sel_t;

  typedef enum logic [2:0] {
    SDA_KEEP,
    SDA_LO,
    SDA_HI,
    SDA_TX,
    SDA_ACK
  } sda_sel_t;

  typedef struct packed {
    scl_sel_t scl_sel;
    sda_sel_t sda_sel;
    logic     ack;       // flag ack_ok on this line write
    logic     rx_out;    // present the received byte
    logic     shift_in;  // sample one read bit
    logic     last;      // ends the run (when a loop, only once the count is out)
    logic     loop;      // jump to target while bits remain
    pc_t      target;
  } ctl_t;

  function automatic pc_t entry_pc(input logic [2:0] req);
    pc_t pc;
    pc = PC_START;
    unique case (req)
      REQ_START:              pc = PC_START;
      REQ_STOP:               pc = PC_STOP;
      REQ_WRITE, REQ_WRINV:   pc = PC_WRITE;
      REQ_ACKCLK:             pc = PC_ACKCLK;
      REQ_RDACK, REQ_RDNACK:  pc = PC_READ;
      default:                pc = PC_START;
    endcase
    return pc;
  endfunction

endpackage

FILE: src/i2cbs_ucode_rom.sv
// microcode table of the i2c master bit sequencer
`timescale 1ns / 1ps

module i2cbs_ucode_rom (
  input  i2cbs_pkg::pc_t  pc,
  output i2cbs_pkg::ctl_t ctl
);

  function automatic i2cbs_pkg::ctl_t uw(
    input i2cbs_pkg::scl_sel_t scl,
    input i2cbs_pkg::sda_sel_t sda,
    input logic                ack,
    input logic                rx_out,
    input logic                shift_in,
    input logic                last,
    input logic                loop,
    input i2cbs_pkg::pc_t      target
  );
    i2cbs_pkg::ctl_t w;
    w.scl_sel  = scl;
    w.sda_sel  = sda;
    w.ack      = ack;
    w.rx_out   = rx_out;
    w.shift_in = shift_in;
    w.last     = last;
    w.loop     = loop;
    w.target   = target;
    return w;
  endfunction

  always_comb begin
    unique case (pc)
      // start: sda falls while scl high
      i2cbs_pkg::pc_t'(0):  ctl = uw(i2cbs_pkg::SCL_HI, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(1):  ctl = uw(i2cbs_pkg::SCL_KEEP, i2cbs_pkg::SDA_HI, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(2):  ctl = uw(i2cbs_pkg::SCL_KEEP, i2cbs_pkg::SDA_LO, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(3):  ctl = uw(i2cbs_pkg::SCL_LO, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b1, 1'b0, i2cbs_pkg::PC_START);
      // stop: sda rises while scl high
      i2cbs_pkg::pc_t'(4):  ctl = uw(i2cbs_pkg::SCL_HI, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(5):  ctl = uw(i2cbs_pkg::SCL_KEEP, i2cbs_pkg::SDA_LO, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(6):  ctl = uw(i2cbs_pkg::SCL_KEEP, i2cbs_pkg::SDA_HI, 1'b0, 1'b0, 1'b0,
                                     1'b1, 1'b0, i2cbs_pkg::PC_START);
      // write byte, msb first
      i2cbs_pkg::pc_t'(7):  ctl = uw(i2cbs_pkg::SCL_LO, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(8):  ctl = uw(i2cbs_pkg::SCL_KEEP, i2cbs_pkg::SDA_TX, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(9):  ctl = uw(i2cbs_pkg::SCL_HI, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(10): ctl = uw(i2cbs_pkg::SCL_LO, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b1, 1'b1, i2cbs_pkg::PC_WR_BIT);
      // ack clock
      i2cbs_pkg::pc_t'(11): ctl = uw(i2cbs_pkg::SCL_HI, i2cbs_pkg::SDA_KEEP, 1'b1, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(12): ctl = uw(i2cbs_pkg::SCL_LO, i2cbs_pkg::SDA_KEEP, 1'b1, 1'b0, 1'b0,
                                     1'b1, 1'b0, i2cbs_pkg::PC_START);
      // read byte, then ack or nack
      i2cbs_pkg::pc_t'(13): ctl = uw(i2cbs_pkg::SCL_LO, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(14): ctl = uw(i2cbs_pkg::SCL_HI, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b1,
                                     1'b0, 1'b1, i2cbs_pkg::PC_READ);
      i2cbs_pkg::pc_t'(15): ctl = uw(i2cbs_pkg::SCL_LO, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(16): ctl = uw(i2cbs_pkg::SCL_KEEP, i2cbs_pkg::SDA_ACK, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(17): ctl = uw(i2cbs_pkg::SCL_HI, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b0, 1'b0, i2cbs_pkg::PC_START);
      i2cbs_pkg::pc_t'(18): ctl = uw(i2cbs_pkg::SCL_LO, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b1, 1'b0,
                                     1'b1, 1'b0, i2cbs_pkg::PC_START);
      // unused addresses end the run without touching the lines
      default:              ctl = uw(i2cbs_pkg::SCL_KEEP, i2cbs_pkg::SDA_KEEP, 1'b0, 1'b0, 1'b0,
                                     1'b1, 1'b0, i2cbs_pkg::PC_START);
    endcase
  end

endmodule

FILE: src/i2c_master_bit_sequencer_core.sv
// top level of the i2c master bit sequencer
`timescale 1ns / 1ps

// Each command word is run by a small microprogram that makes one SCL/SDA
// line write per output word, one per cycle while the output side takes them:
// start 4, stop 3, write and write inverted 25, ack clock 2, read 20 words.
// The last word of a run carries tlast. The step counter walks the microcode
// table and a 3-bit bit counter runs the byte loops. An output stall holds the
// run until the output side takes the word. The next command is taken once
// the last word of the run sits in the output register. Request code 7 is
// taken and makes no words. rx_byte shows the received byte only on the last
// word of a read; ack_ok is set on both words of an ack clock.
module i2c_master_bit_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tx_byte[7:0], rx_bits[15:8]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_out[0], sda_out[1], rx_byte[9:2], ack_ok[10], zero
  output logic        m_tlast    // run_last
);

  i2cbs_pkg::ctl_t     ctl;
  i2cbs_pkg::pc_t      pc;
  i2cbs_pkg::bit_cnt_t bit_cnt;
  logic                busy;
  logic                scl_level;
  logic                sda_level;
  logic [7:0]          shift_reg;
  logic [7:0]          tx_reg;
  logic [7:0]          rx_reg;
  logic [2:0]          req_reg;
  logic                scl_next;
  logic                sda_next;
  logic                step;
  logic                bits_done;
  logic                run_end;
  logic                take_in;

  i2cbs_ucode_rom u_rom (
    .pc  (pc),
    .ctl (ctl)
  );

  assign s_tready  = !busy;
  assign take_in   = s_tvalid && s_tready;
  assign step      = busy && (!m_tvalid || m_tready);
  assign bits_done = (bit_cnt == '0);
  assign run_end   = ctl.last && (!ctl.loop || bits_done);

  always_comb begin
    unique case (ctl.scl_sel)
      i2cbs_pkg::SCL_LO: scl_next = 1'b0;
      i2cbs_pkg::SCL_HI: scl_next = 1'b1;
      default:           scl_next = scl_level;
    endcase
  end

  always_comb begin
    unique case (ctl.sda_sel)
      i2cbs_pkg::SDA_LO:  sda_next = 1'b0;
      i2cbs_pkg::SDA_HI:  sda_next = 1'b1;
      i2cbs_pkg::SDA_TX:  sda_next = tx_reg[bit_cnt] ^ (req_reg == i2cbs_pkg::REQ_WRINV);
      // nack leaves sda high
      i2cbs_pkg::SDA_ACK: sda_next = (req_reg == i2cbs_pkg::REQ_RDNACK);
      default:            sda_next = sda_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      m_tvalid  <= 1'b0;
      scl_level <= 1'b1;
      sda_level <= 1'b1;
      shift_reg <= '0;
      pc        <= i2cbs_pkg::PC_START;
      bit_cnt   <= '0;
    end else begin
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (take_in && s_tuser != i2cbs_pkg::REQ_NONE) begin
        busy    <= 1'b1;
        pc      <= i2cbs_pkg::entry_pc(s_tuser);
        bit_cnt <= i2cbs_pkg::bit_cnt_t'(i2cbs_pkg::ByteBits - 1);
      end
      if (step) begin
        scl_level <= scl_next;
        sda_level <= sda_next;
        if (ctl.shift_in) begin
          shift_reg <= {shift_reg[6:0], rx_reg[bit_cnt]};
        end
        if (ctl.loop && !bits_done) begin
          bit_cnt <= bit_cnt - 1'b1;
          pc      <= ctl.target;
        end else begin
          pc <= pc + 1'b1;
        end
        // reload so a following loop in the same run counts a full byte
        if (ctl.loop && bits_done) begin
          bit_cnt <= i2cbs_pkg::bit_cnt_t'(i2cbs_pkg::ByteBits - 1);
        end
        if (run_end) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // command payload and output word
  always_ff @(posedge clk) begin
    if (take_in) begin
      req_reg <= s_tuser;
      tx_reg  <= s_tdata[7:0];
      rx_reg  <= s_tdata[15:8];
    end
    if (step) begin
      m_tdata <= {5'd0, ctl.ack, (ctl.rx_out ? shift_reg : 8'd0), sda_next, scl_next};
      m_tlast <= run_end;
    end
  end

endmodule
